[src/tmx_pkg.sv]
// Shared types, constants and helper functions for the thruster mixer.
package tmx_pkg;

   // Field widths.
   localparam int OP_W    = 4;
   localparam int ARG_W   = 16;
   localparam int PCT_W   = 8;
   localparam int ABS_W   = 7;
   localparam int SPAN_W  = 10;
   localparam int TGT_W   = 12;
   localparam int MIX_W   = 16;
   localparam int NUM_TGT = 5;

   // Register map.
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;
   localparam logic REG_FORWARD_SPAN = 1'b0;
   localparam logic REG_REVERSE_SPAN = 1'b1;
   localparam logic [SPAN_W-1:0] SPAN_RESET = 10'd500;

   // Division by 100 is done as a multiply by a scaled reciprocal.
   // A percent is carried as pct * RECIP_100, so span * coef >> 24 is
   // floor(span * pct / 100) for every product below 2^17.
   localparam int COEF_W      = 25;
   localparam int PROD_W      = 36;
   localparam int RECIP_SHIFT = 24;
   localparam int STEP_W      = 11;
   localparam logic [COEF_W-1:0] RECIP_100 = 25'd167773;
   localparam logic [COEF_W-1:0] FULL_COEF = 25'd16777300;
   // 99 / 100 in the same scale, turns the floor into a ceiling.
   localparam logic [COEF_W-1:0] CEIL_BIAS = 25'd16609527;

   // Pulse limits in microseconds.
   localparam logic [TGT_W-1:0] NEUTRAL_US = 12'd1500;
   localparam logic [TGT_W-1:0] TARGET_MAX = 12'd4095;
   localparam logic signed [MIX_W-1:0] NEUTRAL_MIX = 16'sd1500;
   localparam logic signed [MIX_W-1:0] LEGACY_MIN  = 16'sd1000;
   localparam logic signed [MIX_W-1:0] LEGACY_MAX  = 16'sd2000;
   localparam logic signed [ARG_W-1:0] PCT_MIN     = -16'sd100;
   localparam logic signed [ARG_W-1:0] PCT_MAX     = 16'sd100;

   // Slots of the target array.
   localparam int TGT_PORT_FWD = 0;
   localparam int TGT_PORT_AFT = 1;
   localparam int TGT_VERT     = 2;
   localparam int TGT_STBD_FWD = 3;
   localparam int TGT_STBD_AFT = 4;

   // Command codes.
   typedef enum logic [OP_W-1:0] {
      OP_THROTTLE  = 4'd0,
      OP_YAW       = 4'd1,
      OP_STRAFE    = 4'd2,
      OP_LIFT      = 4'd3,
      OP_GO        = 4'd4,
      OP_PORT      = 4'd5,
      OP_VERTICAL  = 4'd6,
      OP_STARBOARD = 4'd7,
      OP_STOP      = 4'd8
   } tmx_op_type;

   // One command as held in the input register, with range checks done.
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [ARG_W-1:0]  arg_a;
      logic signed [ARG_W-1:0]  arg_b;
      logic signed [ARG_W-1:0]  arg_c;
      logic                     pct_ok;
      logic [COEF_W-1:0]        pct_coef;
      logic                     a_pulse_ok;
      logic                     b_pulse_ok;
      logic                     c_pulse_ok;
   } tmx_item_type;

   // Span registers as seen by the mixer.
   typedef struct packed {
      logic [SPAN_W-1:0] fwd_span;
      logic [SPAN_W-1:0] rev_span;
   } tmx_cfg_type;

   // Clamp a mixed value into the target range.
   function automatic logic [TGT_W-1:0] sat_target(input logic signed [MIX_W-1:0] x);
      logic [TGT_W-1:0] res;
      if (x < 0) begin
         res = '0;
      end else if (x > $signed({4'b0, TARGET_MAX})) begin
         res = TARGET_MAX;
      end else begin
         res = x[TGT_W-1:0];
      end
      return res;
   endfunction

   // True for a legacy pulse width inside 1000..2000.
   function automatic logic pulse_ok(input logic signed [ARG_W-1:0] x);
      return (x >= LEGACY_MIN) && (x <= LEGACY_MAX);
   endfunction

endpackage

[src/tmx_if.sv]
// Command and result channel interfaces of the thruster mixer.
interface tmx_req_if;
   logic                                valid;
   logic                                ready;
   logic [tmx_pkg::OP_W-1:0]            op;
   logic signed [tmx_pkg::ARG_W-1:0]    arg_a;
   logic signed [tmx_pkg::ARG_W-1:0]    arg_b;
   logic signed [tmx_pkg::ARG_W-1:0]    arg_c;

   modport source (output valid, op, arg_a, arg_b, arg_c, input ready);
   modport sink (input valid, op, arg_a, arg_b, arg_c, output ready);
   modport monitor (input valid, ready, op, arg_a, arg_b, arg_c);
endinterface

interface tmx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tmx_pkg::TGT_W-1:0]   port_fwd_us;
   logic [tmx_pkg::TGT_W-1:0]   port_aft_us;
   logic [tmx_pkg::TGT_W-1:0]   vert_us;
   logic [tmx_pkg::TGT_W-1:0]   stbd_fwd_us;
   logic [tmx_pkg::TGT_W-1:0]   stbd_aft_us;
   logic                        motors_active;

   modport source (output valid, port_fwd_us, port_aft_us, vert_us, stbd_fwd_us,
                   stbd_aft_us, motors_active, input ready);
   modport sink (input valid, port_fwd_us, port_aft_us, vert_us, stbd_fwd_us,
                 stbd_aft_us, motors_active, output ready);
   modport monitor (input valid, ready, port_fwd_us, port_aft_us, vert_us,
                    stbd_fwd_us, stbd_aft_us, motors_active);
endinterface

[src/tmx_csr.sv]
// APB register block holding the forward and reverse span registers.
module tmx_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tmx_pkg::ADDR_W-1:0]    paddr,
   input  logic [tmx_pkg::DATA_W-1:0]    pwdata,
   output logic [tmx_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output tmx_pkg::tmx_cfg_type          cfg
);

   logic [tmx_pkg::SPAN_W-1:0] fwd_span_ff;
   logic [tmx_pkg::SPAN_W-1:0] rev_span_ff;
   logic                       wr_en;
   logic                       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   // Register writes land in the access phase; only the low ten bits are kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_span_ff <= tmx_pkg::SPAN_RESET;
         rev_span_ff <= tmx_pkg::SPAN_RESET;
      end else if (wr_en) begin
         if (reg_sel == tmx_pkg::REG_FORWARD_SPAN) begin
            fwd_span_ff <= pwdata[tmx_pkg::SPAN_W-1:0];
         end else begin
            rev_span_ff <= pwdata[tmx_pkg::SPAN_W-1:0];
         end
      end
   end

   // Read-back mux.
   always_comb begin
      if (reg_sel == tmx_pkg::REG_FORWARD_SPAN) begin
         prdata = {{(tmx_pkg::DATA_W-tmx_pkg::SPAN_W){1'b0}}, fwd_span_ff};
      end else begin
         prdata = {{(tmx_pkg::DATA_W-tmx_pkg::SPAN_W){1'b0}}, rev_span_ff};
      end
   end

   assign cfg.fwd_span = fwd_span_ff;
   assign cfg.rev_span = rev_span_ff;

endmodule

[src/tmx_intake.sv]
// Input register stage: range checks and percent scaling of each command.
module tmx_intake (
   input  logic                   clock,
   input  logic                   reset,
   tmx_req_if.sink                req,
   input  logic                   core_ready,
   output logic                   item_valid,
   output tmx_pkg::tmx_item_type  item
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   tmx_pkg::tmx_item_type in_item_ff;
   tmx_pkg::tmx_item_type in_item_in;
   logic                  accept;
   logic                  pct_ok;
   logic [tmx_pkg::ABS_W-1:0] pct_abs;

   // The stage takes a beat when empty or when its item moves on this cycle.
   assign req.ready = !reset && (!in_valid_ff || core_ready);
   assign accept    = req.valid && req.ready;

   // Percent check and magnitude scaled by the reciprocal of 100.
   always_comb begin
      pct_ok  = (req.arg_a >= tmx_pkg::PCT_MIN) && (req.arg_a <= tmx_pkg::PCT_MAX);
      pct_abs = req.arg_a[tmx_pkg::ARG_W-1] ? tmx_pkg::ABS_W'(-req.arg_a)
                                            : req.arg_a[tmx_pkg::ABS_W-1:0];
      in_item_in.op         = req.op;
      in_item_in.arg_a      = req.arg_a;
      in_item_in.arg_b      = req.arg_b;
      in_item_in.arg_c      = req.arg_c;
      in_item_in.pct_ok     = pct_ok;
      in_item_in.pct_coef   = pct_ok
         ? {{(tmx_pkg::COEF_W-tmx_pkg::ABS_W){1'b0}}, pct_abs} * tmx_pkg::RECIP_100
         : '0;
      in_item_in.a_pulse_ok = tmx_pkg::pulse_ok(req.arg_a);
      in_item_in.b_pulse_ok = tmx_pkg::pulse_ok(req.arg_b);
      in_item_in.c_pulse_ok = tmx_pkg::pulse_ok(req.arg_c);
   end

   assign in_valid_in = accept || (in_valid_ff && !core_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload register, loaded on every accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= in_item_in;
      end
   end

   assign item_valid = in_valid_ff;
   assign item       = in_item_ff;

endmodule

[src/tmx_core.sv]
// Mixer core: command state, thrust mixing and the result register.
module tmx_core (
   input  logic                   clock,
   input  logic                   reset,
   input  tmx_pkg::tmx_cfg_type   cfg,
   input  logic                   item_valid,
   input  tmx_pkg::tmx_item_type  item,
   output logic                   core_ready,
   tmx_rsp_if.source              rsp
);

   localparam int TOP = tmx_pkg::RECIP_SHIFT + tmx_pkg::STEP_W - 1;
   localparam int PAD_SPAN = tmx_pkg::PROD_W - tmx_pkg::SPAN_W;
   localparam int PAD_COEF = tmx_pkg::PROD_W - tmx_pkg::COEF_W;
   localparam int PAD_STEP = tmx_pkg::MIX_W - tmx_pkg::STEP_W;
   localparam logic signed [tmx_pkg::MIX_W-1:0] FWD_LIMIT = 16'sd2000;
   localparam logic signed [tmx_pkg::MIX_W-1:0] REV_LIMIT = 16'sd1000;

   // Stored command state; the targets double as the result register.
   logic signed [tmx_pkg::PCT_W-1:0] thr_pct_ff, yaw_pct_ff, str_pct_ff;
   logic signed [tmx_pkg::PCT_W-1:0] thr_pct_in, yaw_pct_in, str_pct_in;
   logic [tmx_pkg::COEF_W-1:0]       thr_coef_ff, yaw_coef_ff, str_coef_ff;
   logic [tmx_pkg::COEF_W-1:0]       thr_coef_in, yaw_coef_in, str_coef_in;
   logic [tmx_pkg::TGT_W-1:0]        tgt_ff [tmx_pkg::NUM_TGT];
   logic [tmx_pkg::TGT_W-1:0]        tgt_in [tmx_pkg::NUM_TGT];
   logic                             active_ff, active_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             fire;

   // Mixing intermediates.
   logic                             set_thr, set_yaw, set_str;
   logic                             thr_neg;
   logic [tmx_pkg::SPAN_W-1:0]       span;
   logic [tmx_pkg::PROD_W-1:0]       p_prod, lim_prod, st_prod;
   logic [tmx_pkg::STEP_W-1:0]       p_step, limit, st_raw, st_mag;
   logic signed [tmx_pkg::MIX_W-1:0] p_us, turn, turn_mag16, off, off_raw, pf, sf, st;
   logic [tmx_pkg::ABS_W-1:0]        yaw_abs;
   logic [8:0]                       yaw_x5;
   logic [7:0]                       turn_mag;
   logic signed [tmx_pkg::COEF_W+1:0] k_coef;
   logic [tmx_pkg::COEF_W+1:0]       k_abs;
   logic signed [tmx_pkg::MIX_W-1:0] lift_us;

   assign core_ready = !rsp_valid_ff || rsp.ready;
   assign fire       = item_valid && core_ready;

   // Percent selection: a remix sees the percent this very command stores.
   always_comb begin
      set_thr = (item.op == tmx_pkg::OP_THROTTLE) && item.pct_ok;
      set_yaw = (item.op == tmx_pkg::OP_YAW) && item.pct_ok;
      set_str = (item.op == tmx_pkg::OP_STRAFE) && item.pct_ok;
      thr_pct_in  = set_thr ? item.arg_a[tmx_pkg::PCT_W-1:0] : thr_pct_ff;
      yaw_pct_in  = set_yaw ? item.arg_a[tmx_pkg::PCT_W-1:0] : yaw_pct_ff;
      str_pct_in  = set_str ? item.arg_a[tmx_pkg::PCT_W-1:0] : str_pct_ff;
      thr_coef_in = set_thr ? item.pct_coef : thr_coef_ff;
      yaw_coef_in = set_yaw ? item.pct_coef : yaw_coef_ff;
      str_coef_in = set_str ? item.pct_coef : str_coef_ff;
   end

   // Base pulse from throttle; a negative throttle rounds the step up.
   always_comb begin
      thr_neg = thr_pct_in[tmx_pkg::PCT_W-1];
      span    = thr_neg ? cfg.rev_span : cfg.fwd_span;
      p_prod  = {{PAD_SPAN{1'b0}}, span} * {{PAD_COEF{1'b0}}, thr_coef_in}
              + (thr_neg ? {{PAD_COEF{1'b0}}, tmx_pkg::CEIL_BIAS} : '0);
      p_step  = p_prod[TOP:tmx_pkg::RECIP_SHIFT];
      p_us    = thr_neg ? tmx_pkg::NEUTRAL_MIX - $signed({{PAD_STEP{1'b0}}, p_step})
                        : tmx_pkg::NEUTRAL_MIX + $signed({{PAD_STEP{1'b0}}, p_step});
   end

   // Yaw turn is 2.5 times the percent, truncated toward zero.
   always_comb begin
      yaw_abs    = yaw_pct_in[tmx_pkg::PCT_W-1] ? tmx_pkg::ABS_W'(-yaw_pct_in)
                                                : yaw_pct_in[tmx_pkg::ABS_W-1:0];
      yaw_x5     = {2'b0, yaw_abs} + {yaw_abs, 2'b0};
      turn_mag   = yaw_x5[8:1];
      turn_mag16 = $signed({8'b0, turn_mag});
      turn       = yaw_pct_in[tmx_pkg::PCT_W-1] ? -turn_mag16 : turn_mag16;
   end

   // Offset priority: shift both sides back inside the 1000..2000 window.
   always_comb begin
      if (!thr_neg) begin
         off_raw = turn_mag16 + p_us - FWD_LIMIT;
      end else begin
         off_raw = REV_LIMIT - p_us + turn_mag16;
      end
      off = (off_raw < 0) ? '0 : off_raw;
      if (!thr_neg) begin
         pf = p_us + turn - off;
         sf = p_us - turn - off;
      end else begin
         pf = p_us + turn + off;
         sf = p_us - turn + off;
      end
   end

   // Strafe, clamped to the authority left by throttle and yaw.
   always_comb begin
      k_coef = $signed({2'b0, tmx_pkg::FULL_COEF}) - $signed({2'b0, thr_coef_in})
             - $signed({2'b0, yaw_coef_in});
      k_abs  = (k_coef < 0) ? -k_coef : k_coef;
      lim_prod = {{PAD_SPAN{1'b0}}, cfg.rev_span}
               * {{PAD_COEF{1'b0}}, k_abs[tmx_pkg::COEF_W-1:0]};
      st_prod  = {{PAD_SPAN{1'b0}}, cfg.rev_span} * {{PAD_COEF{1'b0}}, str_coef_in};
      limit  = lim_prod[TOP:tmx_pkg::RECIP_SHIFT];
      st_raw = st_prod[TOP:tmx_pkg::RECIP_SHIFT];
      st_mag = (st_raw > limit) ? limit : st_raw;
      st     = str_pct_in[tmx_pkg::PCT_W-1] ? -$signed({{PAD_STEP{1'b0}}, st_mag})
                                            : $signed({{PAD_STEP{1'b0}}, st_mag});
   end

   // Lift maps the percent onto 1000..2000.
   assign lift_us = tmx_pkg::NEUTRAL_MIX + item.arg_a + (item.arg_a <<< 2);

   // Next targets by command.
   always_comb begin
      for (int i = 0; i < tmx_pkg::NUM_TGT; i++) begin
         tgt_in[i] = tgt_ff[i];
      end
      case (item.op)
         tmx_pkg::OP_THROTTLE, tmx_pkg::OP_YAW, tmx_pkg::OP_STRAFE: begin
            tgt_in[tmx_pkg::TGT_PORT_FWD] = tmx_pkg::sat_target(pf + st);
            tgt_in[tmx_pkg::TGT_PORT_AFT] = tmx_pkg::sat_target(pf - st);
            tgt_in[tmx_pkg::TGT_STBD_FWD] = tmx_pkg::sat_target(sf - st);
            tgt_in[tmx_pkg::TGT_STBD_AFT] = tmx_pkg::sat_target(sf + st);
         end
         tmx_pkg::OP_LIFT: begin
            if (item.pct_ok) begin
               tgt_in[tmx_pkg::TGT_VERT] = lift_us[tmx_pkg::TGT_W-1:0];
            end
         end
         tmx_pkg::OP_GO: begin
            if (item.a_pulse_ok && item.b_pulse_ok && item.c_pulse_ok) begin
               tgt_in[tmx_pkg::TGT_PORT_FWD] = item.arg_a[tmx_pkg::TGT_W-1:0];
               tgt_in[tmx_pkg::TGT_PORT_AFT] = item.arg_a[tmx_pkg::TGT_W-1:0];
               tgt_in[tmx_pkg::TGT_VERT]     = item.arg_b[tmx_pkg::TGT_W-1:0];
               tgt_in[tmx_pkg::TGT_STBD_FWD] = item.arg_c[tmx_pkg::TGT_W-1:0];
               tgt_in[tmx_pkg::TGT_STBD_AFT] = item.arg_c[tmx_pkg::TGT_W-1:0];
            end
         end
         tmx_pkg::OP_PORT: begin
            if (item.a_pulse_ok) begin
               tgt_in[tmx_pkg::TGT_PORT_FWD] = item.arg_a[tmx_pkg::TGT_W-1:0];
               tgt_in[tmx_pkg::TGT_PORT_AFT] = item.arg_a[tmx_pkg::TGT_W-1:0];
            end
         end
         tmx_pkg::OP_VERTICAL: begin
            if (item.a_pulse_ok) begin
               tgt_in[tmx_pkg::TGT_VERT] = item.arg_a[tmx_pkg::TGT_W-1:0];
            end
         end
         tmx_pkg::OP_STARBOARD: begin
            if (item.a_pulse_ok) begin
               tgt_in[tmx_pkg::TGT_STBD_FWD] = item.arg_a[tmx_pkg::TGT_W-1:0];
               tgt_in[tmx_pkg::TGT_STBD_AFT] = item.arg_a[tmx_pkg::TGT_W-1:0];
            end
         end
         tmx_pkg::OP_STOP: begin
            for (int i = 0; i < tmx_pkg::NUM_TGT; i++) begin
               tgt_in[i] = tmx_pkg::NEUTRAL_US;
            end
         end
         default: begin
         end
      endcase
   end

   // Any target away from neutral.
   always_comb begin
      active_in = 1'b0;
      for (int i = 0; i < tmx_pkg::NUM_TGT; i++) begin
         if (tgt_in[i] != tmx_pkg::NEUTRAL_US) begin
            active_in = 1'b1;
         end
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp.ready);

   // State and result register update once per fired command.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         thr_pct_ff   <= '0;
         yaw_pct_ff   <= '0;
         str_pct_ff   <= '0;
         thr_coef_ff  <= '0;
         yaw_coef_ff  <= '0;
         str_coef_ff  <= '0;
         for (int i = 0; i < tmx_pkg::NUM_TGT; i++) begin
            tgt_ff[i] <= tmx_pkg::NEUTRAL_US;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            active_ff   <= active_in;
            thr_pct_ff  <= thr_pct_in;
            yaw_pct_ff  <= yaw_pct_in;
            str_pct_ff  <= str_pct_in;
            thr_coef_ff <= thr_coef_in;
            yaw_coef_ff <= yaw_coef_in;
            str_coef_ff <= str_coef_in;
            for (int i = 0; i < tmx_pkg::NUM_TGT; i++) begin
               tgt_ff[i] <= tgt_in[i];
            end
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.port_fwd_us   = tgt_ff[tmx_pkg::TGT_PORT_FWD];
   assign rsp.port_aft_us   = tgt_ff[tmx_pkg::TGT_PORT_AFT];
   assign rsp.vert_us       = tgt_ff[tmx_pkg::TGT_VERT];
   assign rsp.stbd_fwd_us   = tgt_ff[tmx_pkg::TGT_STBD_FWD];
   assign rsp.stbd_aft_us   = tgt_ff[tmx_pkg::TGT_STBD_AFT];
   assign rsp.motors_active = active_ff;

endmodule

[src/thruster_mix_throttle_yaw_strafe.sv]
// Top level of the five-thruster mixer with throttle, yaw and strafe priority.
//
//   Channel   Direction  Handshake           Beat contents
//   req_bus   in         valid/ready         op, arg_a, arg_b, arg_c
//   rsp_bus   out        valid/ready         five pulse targets, motors_active
//   APB       in         psel/penable/pready forward_span at 0x0, reverse_span at 0x4
//
// One command is accepted per cycle while the result channel does not stall.
// It is held in the input register, then taken through the mixer into the target
// registers, from which its result is offered. Reset is synchronous and restores
// the spans to 500, the percents to zero and all targets to 1500. A stalled result
// holds the target registers, and the input register still takes one more beat.
module thruster_mix_throttle_yaw_strafe (
   input  logic                          clock,
   input  logic                          reset,
   tmx_req_if.sink                       req_bus,
   tmx_rsp_if.source                     rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tmx_pkg::ADDR_W-1:0]    paddr,
   input  logic [tmx_pkg::DATA_W-1:0]    pwdata,
   output logic [tmx_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   tmx_pkg::tmx_cfg_type  cfg;
   tmx_pkg::tmx_item_type item;
   logic                  item_valid;
   logic                  core_ready;

   tmx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tmx_intake u_intake (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .core_ready (core_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   tmx_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .core_ready (core_ready),
      .rsp        (rsp_bus)
   );

endmodule

[src/tmx_checker.sv]
// Port-level checks of the thruster mixer, bound to the top level.
module tmx_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [tmx_pkg::TGT_W-1:0] port_fwd_us,
   input  logic [tmx_pkg::TGT_W-1:0] port_aft_us,
   input  logic [tmx_pkg::TGT_W-1:0] vert_us,
   input  logic [tmx_pkg::TGT_W-1:0] stbd_fwd_us,
   input  logic [tmx_pkg::TGT_W-1:0] stbd_aft_us,
   input  logic                      motors_active
);

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A new result must trace back to an accepted command beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a matching command beat");

   // A stalled result beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(port_fwd_us) && $stable(port_aft_us) &&
         $stable(vert_us) && $stable(stbd_fwd_us) &&
         $stable(stbd_aft_us) && $stable(motors_active))
      else $error("result payload changed while stalled");

endmodule

bind thruster_mix_throttle_yaw_strafe tmx_checker u_tmx_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .port_fwd_us   (rsp_bus.port_fwd_us),
   .port_aft_us   (rsp_bus.port_aft_us),
   .vert_us       (rsp_bus.vert_us),
   .stbd_fwd_us   (rsp_bus.stbd_fwd_us),
   .stbd_aft_us   (rsp_bus.stbd_aft_us),
   .motors_active (rsp_bus.motors_active)
);
